### rtl/depth_point_filter_stats_unit_assert.svh
// Assertion macros for the checker of the depth point filter.
`ifndef DEPTH_POINT_FILTER_STATS_UNIT_ASSERT_SVH
`define DEPTH_POINT_FILTER_STATS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpfs: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpfs: next-cycle check failed");

`endif

### rtl/dpfs_pkg.sv
package dpfs_pkg;

  // Field widths.
  localparam int DISP_W     = 16;
  localparam int COORD_W    = 32;
  localparam int FRAME_W    = 13;
  localparam int DEC_W      = 5;
  localparam int ROI_W      = 13;
  localparam int DEPTH_W    = 31;
  localparam int COL_W      = 13;
  localparam int ROW_W      = 12;
  localparam int GRID_W     = 12;
  localparam int PHASE_W    = 5;
  localparam int COUNT_W    = 24;
  localparam int SUM_W      = 56;
  localparam int STAT_W     = 64;
  localparam int STAT_ID_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register reset values.
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST = FRAME_W'(640);
  localparam logic [DEC_W-1:0]   DECIMATION_RST  = DEC_W'(1);
  localparam logic [ROI_W-1:0]   ROI_END_RST     = ROI_W'(4096);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX_RST   = DEPTH_W'(655360);

  // Result kinds.
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_STAT  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_DECIMATION,
    CFG_ROI_COL_START,
    CFG_ROI_COL_END,
    CFG_ROI_ROW_START,
    CFG_ROI_ROW_END,
    CFG_DEPTH_MIN,
    CFG_DEPTH_MAX
  } dpfs_cfg_idx_e;

  // Statistic identifiers, in the order they leave the block.
  typedef enum logic [STAT_ID_W-1:0] {
    STAT_CANDIDATES,
    STAT_ROI,
    STAT_DISPARITY,
    STAT_NONFINITE,
    STAT_DEPTH,
    STAT_ABS,
    STAT_ACCEPTED,
    STAT_MIN,
    STAT_MAX,
    STAT_SUM
  } dpfs_stat_e;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_width;
    logic [DEC_W-1:0]   decimation;
    logic [ROI_W-1:0]   roi_col_start;
    logic [ROI_W-1:0]   roi_col_end;
    logic [ROI_W-1:0]   roi_row_start;
    logic [ROI_W-1:0]   roi_row_end;
    logic [DEPTH_W-1:0] depth_min;
    logic [DEPTH_W-1:0] depth_max;
  } dpfs_cfg_t;

  typedef struct packed {
    logic signed [DISP_W-1:0]  disparity;
    logic                      disparity_ok;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      point_ok;
    logic                      end_of_frame;
  } dpfs_pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] candidates;
    logic [COUNT_W-1:0] roi;
    logic [COUNT_W-1:0] disparity;
    logic [COUNT_W-1:0] nonfinite;
    logic [COUNT_W-1:0] depth;
    logic [COUNT_W-1:0] abs_limit;
    logic [COUNT_W-1:0] accepted;
  } dpfs_counts_t;

  // Everything one pixel hands to the result stage.
  typedef struct packed {
    logic                      valid;
    logic                      pt_valid;
    logic                      eof;
    logic [GRID_W-1:0]         grid_col;
    logic [GRID_W-1:0]         grid_row;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    dpfs_counts_t              counts;
    logic [DEPTH_W-1:0]        least;
    logic [DEPTH_W-1:0]        greatest;
    logic [SUM_W-1:0]          sum;
  } dpfs_load_t;

endpackage

### rtl/dpfs_filter.sv
module dpfs_filter #(
  parameter int MAX_WIDTH      = 4096,
  parameter int MAX_DECIMATION = 16,
  parameter int MIN_DISPARITY  = 0,
  parameter int MAX_ABS_COORD  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dpfs_pkg::dpfs_cfg_t   cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dpfs_pkg::dpfs_pixel_t pixel_i,
  input  logic                 load_ok_i,
  output dpfs_pkg::dpfs_load_t  load_o
);
  import dpfs_pkg::*;

  localparam int DISP_EXT_W = DISP_W + 2;
  localparam int MAG_W      = COORD_W + 1;
  localparam logic signed [DISP_EXT_W-1:0] DISP_FLOOR = DISP_EXT_W'(MIN_DISPARITY * 16);
  localparam logic [MAG_W-1:0] ABS_LIMIT = MAG_W'(MAX_ABS_COORD);
  localparam logic ABS_ON = (MAX_ABS_COORD > 0);

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input logic [COORD_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[COORD_W-1], v};
    magnitude = v[COORD_W-1] ? (~ext + 1'b1) : ext;
  endfunction

  dpfs_pixel_t        pix_q;
  logic               pix_valid_q;
  logic               adv;

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [PHASE_W-1:0] cph_q, cph_d, rph_q, rph_d;
  logic [GRID_W-1:0]  gcol_q, gcol_d, gline_q, gline_d;
  dpfs_counts_t       cnt_q, cnt_upd;
  logic [DEPTH_W-1:0] least_q, least_upd, greatest_q, greatest_upd;
  logic [SUM_W-1:0]   sum_q, sum_upd;
  logic [SUM_W:0]     sum_ext;

  logic [FRAME_W-1:0] w_eff;
  logic [DEC_W-1:0]   d_eff;
  logic               candidate, roi_out, disp_bad, range_bad, abs_bad, accept, any;
  logic signed [DISP_EXT_W-1:0] disp_ext;
  logic signed [COORD_W:0]      z_ext, dmin_ext, dmax_ext;
  logic [DEPTH_W-1:0]           z_u;

  // Input register; it drains whenever the result stage can take a new item.
  assign adv        = pix_valid_q && load_ok_i;
  assign in_ready_o = !pix_valid_q || load_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      pix_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pix_q <= pixel_i;
    end
  end

  // Frame width and decimation as used, with odd values brought into range.
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w_eff = FRAME_W'(1);
    end else if (32'(cfg_i.frame_width) > MAX_WIDTH) begin
      w_eff = FRAME_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_i.frame_width;
    end
    if (cfg_i.decimation == '0) begin
      d_eff = DEC_W'(1);
    end else if (32'(cfg_i.decimation) > MAX_DECIMATION) begin
      d_eff = DEC_W'(MAX_DECIMATION);
    end else begin
      d_eff = cfg_i.decimation;
    end
  end

  // Rejection tests; an empty region on an axis spans the whole frame.
  always_comb begin
    logic col_full, row_full, col_out, row_out;
    col_full = cfg_i.roi_col_end <= cfg_i.roi_col_start;
    row_full = cfg_i.roi_row_end <= cfg_i.roi_row_start;
    col_out  = !col_full && (col_q < cfg_i.roi_col_start || col_q >= cfg_i.roi_col_end);
    row_out  = !row_full && ({1'b0, row_q} < cfg_i.roi_row_start ||
                             {1'b0, row_q} >= cfg_i.roi_row_end);
    roi_out  = col_out || row_out;

    disp_ext = $signed({{2{pix_q.disparity[DISP_W-1]}}, pix_q.disparity});
    disp_bad = !pix_q.disparity_ok || (disp_ext <= DISP_FLOOR);

    z_ext     = $signed({pix_q.point_z[COORD_W-1], pix_q.point_z});
    dmin_ext  = $signed({2'b00, cfg_i.depth_min});
    dmax_ext  = $signed({2'b00, cfg_i.depth_max});
    range_bad = (z_ext < dmin_ext) || (z_ext > dmax_ext);

    abs_bad = ABS_ON && (magnitude(pix_q.point_x) > ABS_LIMIT ||
                         magnitude(pix_q.point_y) > ABS_LIMIT ||
                         magnitude(pix_q.point_z) > ABS_LIMIT);

    candidate = adv && (cph_q == '0) && (rph_q == '0);
    accept    = candidate && !roi_out && !disp_bad && pix_q.point_ok && !range_bad && !abs_bad;
  end

  // Counters: the first failing test takes the pixel.
  always_comb begin
    cnt_upd = cnt_q;
    if (candidate) begin
      cnt_upd.candidates = sat_inc(cnt_q.candidates);
      if (roi_out) begin
        cnt_upd.roi = sat_inc(cnt_q.roi);
      end else if (disp_bad) begin
        cnt_upd.disparity = sat_inc(cnt_q.disparity);
      end else if (!pix_q.point_ok) begin
        cnt_upd.nonfinite = sat_inc(cnt_q.nonfinite);
      end else if (range_bad) begin
        cnt_upd.depth = sat_inc(cnt_q.depth);
      end else if (abs_bad) begin
        cnt_upd.abs_limit = sat_inc(cnt_q.abs_limit);
      end else begin
        cnt_upd.accepted = sat_inc(cnt_q.accepted);
      end
    end
  end

  // Depth statistics; an accepted depth is never negative.
  always_comb begin
    z_u          = pix_q.point_z[DEPTH_W-1:0];
    least_upd    = (accept && z_u < least_q) ? z_u : least_q;
    greatest_upd = (accept && z_u > greatest_q) ? z_u : greatest_q;
    sum_ext      = {1'b0, sum_q} + (SUM_W + 1)'(z_u);
    if (!accept) begin
      sum_upd = sum_q;
    end else if (sum_ext[SUM_W]) begin
      sum_upd = '1;
    end else begin
      sum_upd = sum_ext[SUM_W-1:0];
    end
    any = cnt_upd.accepted != '0;
  end

  // Raster position and decimation phase.
  always_comb begin
    logic [COL_W-1:0]   col_inc;
    logic [PHASE_W-1:0] cph_inc, rph_inc;
    col_inc = col_q + 1'b1;
    cph_inc = cph_q + 1'b1;
    rph_inc = rph_q + 1'b1;
    col_d   = col_inc;
    row_d   = row_q;
    cph_d   = cph_inc;
    rph_d   = rph_q;
    gcol_d  = gcol_q;
    gline_d = gline_q;
    if ({1'b0, cph_inc} >= {1'b0, d_eff}) begin
      cph_d  = '0;
      gcol_d = gcol_q + 1'b1;
    end
    if (col_inc >= w_eff) begin
      col_d  = '0;
      cph_d  = '0;
      gcol_d = '0;
      row_d  = row_q + 1'b1;
      rph_d  = rph_inc;
      if ({1'b0, rph_inc} >= {1'b0, d_eff}) begin
        rph_d   = '0;
        gline_d = gline_q + 1'b1;
      end
    end
  end

  // Frame state; the end-of-frame pixel clears it all.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      cph_q      <= '0;
      rph_q      <= '0;
      gcol_q     <= '0;
      gline_q    <= '0;
      cnt_q      <= '0;
      least_q    <= '1;
      greatest_q <= '0;
      sum_q      <= '0;
    end else if (adv) begin
      if (pix_q.end_of_frame) begin
        col_q      <= '0;
        row_q      <= '0;
        cph_q      <= '0;
        rph_q      <= '0;
        gcol_q     <= '0;
        gline_q    <= '0;
        cnt_q      <= '0;
        least_q    <= '1;
        greatest_q <= '0;
        sum_q      <= '0;
      end else begin
        col_q      <= col_d;
        row_q      <= row_d;
        cph_q      <= cph_d;
        rph_q      <= rph_d;
        gcol_q     <= gcol_d;
        gline_q    <= gline_d;
        cnt_q      <= cnt_upd;
        least_q    <= least_upd;
        greatest_q <= greatest_upd;
        sum_q      <= sum_upd;
      end
    end
  end

  // Hand-over to the result stage, with the frame totals after this pixel.
  always_comb begin
    load_o.valid    = adv;
    load_o.pt_valid = accept;
    load_o.eof      = pix_q.end_of_frame;
    load_o.grid_col = gcol_q;
    load_o.grid_row = gline_q;
    load_o.x        = pix_q.point_x;
    load_o.y        = pix_q.point_y;
    load_o.z        = pix_q.point_z;
    load_o.counts   = cnt_upd;
    load_o.least    = any ? least_upd : '0;
    load_o.greatest = any ? greatest_upd : '0;
    load_o.sum      = any ? sum_upd : '0;
  end

endmodule

### rtl/dpfs_result.sv
module dpfs_result (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dpfs_pkg::dpfs_load_t       load_i,
  output logic                      load_ok_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      kind_o,
  output logic [dpfs_pkg::GRID_W-1:0]     grid_col_o,
  output logic [dpfs_pkg::GRID_W-1:0]     grid_row_o,
  output logic signed [dpfs_pkg::COORD_W-1:0] out_x_o,
  output logic signed [dpfs_pkg::COORD_W-1:0] out_y_o,
  output logic signed [dpfs_pkg::COORD_W-1:0] out_z_o,
  output logic [dpfs_pkg::STAT_ID_W-1:0]  stat_id_o,
  output logic signed [dpfs_pkg::STAT_W-1:0] stat_value_o,
  output logic                      last_o
);
  import dpfs_pkg::*;

  dpfs_load_t  data_q;
  logic        pt_valid_q, st_active_q;
  dpfs_stat_e  st_id_q;
  logic        final_elem, pop, load;
  logic [STAT_W-1:0] stat_val;

  // A new result set may enter once the one on show is the final one taken.
  assign out_valid_o = pt_valid_q || st_active_q;
  assign final_elem  = pt_valid_q ? !st_active_q : (st_id_q == STAT_SUM);
  assign load_ok_o   = !out_valid_o || (out_ready_i && final_elem);
  assign pop         = out_valid_o && out_ready_i;
  assign load        = load_i.valid && load_ok_o;

  // Point first; at end of frame, the ten statistics one per taken item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q  <= 1'b0;
      st_active_q <= 1'b0;
      st_id_q     <= STAT_CANDIDATES;
    end else if (load) begin
      pt_valid_q  <= load_i.pt_valid;
      st_active_q <= load_i.eof;
      st_id_q     <= STAT_CANDIDATES;
    end else if (pop) begin
      if (pt_valid_q) begin
        pt_valid_q <= 1'b0;
      end else if (st_id_q == STAT_SUM) begin
        st_active_q <= 1'b0;
      end else begin
        st_id_q <= dpfs_stat_e'(st_id_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= load_i;
    end
  end

  // Statistic selection.
  always_comb begin
    case (st_id_q)
      STAT_CANDIDATES: stat_val = STAT_W'(data_q.counts.candidates);
      STAT_ROI:        stat_val = STAT_W'(data_q.counts.roi);
      STAT_DISPARITY:  stat_val = STAT_W'(data_q.counts.disparity);
      STAT_NONFINITE:  stat_val = STAT_W'(data_q.counts.nonfinite);
      STAT_DEPTH:      stat_val = STAT_W'(data_q.counts.depth);
      STAT_ABS:        stat_val = STAT_W'(data_q.counts.abs_limit);
      STAT_ACCEPTED:   stat_val = STAT_W'(data_q.counts.accepted);
      STAT_MIN:        stat_val = STAT_W'(data_q.least);
      STAT_MAX:        stat_val = STAT_W'(data_q.greatest);
      STAT_SUM:        stat_val = STAT_W'(data_q.sum);
      default:         stat_val = '0;
    endcase
  end

  // Output fields; the unused half of each kind reads as zero.
  always_comb begin
    if (pt_valid_q) begin
      kind_o       = KIND_POINT;
      grid_col_o   = data_q.grid_col;
      grid_row_o   = data_q.grid_row;
      out_x_o      = data_q.x;
      out_y_o      = data_q.y;
      out_z_o      = data_q.z;
      stat_id_o    = STAT_CANDIDATES;
      stat_value_o = '0;
      last_o       = 1'b0;
    end else begin
      kind_o       = KIND_STAT;
      grid_col_o   = '0;
      grid_row_o   = '0;
      out_x_o      = '0;
      out_y_o      = '0;
      out_z_o      = '0;
      stat_id_o    = st_id_q;
      stat_value_o = $signed(stat_val);
      last_o       = (st_id_q == STAT_SUM);
    end
  end

endmodule

### rtl/depth_point_filter_stats_unit.sv
// Depth point filter with frame statistics. Takes one pixel of a reprojected
// depth frame per cycle in raster order unless stalled, keeps pixels
// on the decimation grid, rejects them by region, disparity, finiteness,
// depth range and absolute coordinate limit, and sends each surviving point
// out with its grid column and row. The pixel marked end of frame is
// followed by ten statistic items (counts, depth minimum, maximum and sum),
// the last one flagged, after which all counters clear. Throughput is one
// pixel per cycle while the outputs take items; a pixel passes the input
// register, then the result register. The result register sends one item
// per cycle when taken, so an end-of-frame pixel stalls the input until its
// statistics and any point are taken. No clearing pass follows reset.
// The user must write configuration only while idle; unchecked by the block.
module depth_point_filter_stats_unit #(
  parameter int MAX_WIDTH      = 4096,
  parameter int MAX_DECIMATION = 16,
  parameter int MIN_DISPARITY  = 0,
  parameter int MAX_ABS_COORD  = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dpfs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dpfs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [dpfs_pkg::DISP_W-1:0]  disparity_i,
  input  logic                                disparity_ok_i,
  input  logic signed [dpfs_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [dpfs_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [dpfs_pkg::COORD_W-1:0] point_z_i,
  input  logic                                point_ok_i,
  input  logic                                end_of_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic [dpfs_pkg::GRID_W-1:0]         grid_col_o,
  output logic [dpfs_pkg::GRID_W-1:0]         grid_row_o,
  output logic signed [dpfs_pkg::COORD_W-1:0] out_x_o,
  output logic signed [dpfs_pkg::COORD_W-1:0] out_y_o,
  output logic signed [dpfs_pkg::COORD_W-1:0] out_z_o,
  output logic [dpfs_pkg::STAT_ID_W-1:0]      stat_id_o,
  output logic signed [dpfs_pkg::STAT_W-1:0]  stat_value_o,
  output logic                                last_o
);
  import dpfs_pkg::*;

  dpfs_cfg_t   cfg_q;
  dpfs_pixel_t pixel;
  dpfs_load_t  load;
  logic        load_ok;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= FRAME_WIDTH_RST;
      cfg_q.decimation    <= DECIMATION_RST;
      cfg_q.roi_col_start <= '0;
      cfg_q.roi_col_end   <= ROI_END_RST;
      cfg_q.roi_row_start <= '0;
      cfg_q.roi_row_end   <= ROI_END_RST;
      cfg_q.depth_min     <= '0;
      cfg_q.depth_max     <= DEPTH_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dpfs_cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data_i[FRAME_W-1:0];
        CFG_DECIMATION:    cfg_q.decimation    <= cfg_data_i[DEC_W-1:0];
        CFG_ROI_COL_START: cfg_q.roi_col_start <= cfg_data_i[ROI_W-1:0];
        CFG_ROI_COL_END:   cfg_q.roi_col_end   <= cfg_data_i[ROI_W-1:0];
        CFG_ROI_ROW_START: cfg_q.roi_row_start <= cfg_data_i[ROI_W-1:0];
        CFG_ROI_ROW_END:   cfg_q.roi_row_end   <= cfg_data_i[ROI_W-1:0];
        CFG_DEPTH_MIN:     cfg_q.depth_min     <= cfg_data_i[DEPTH_W-1:0];
        CFG_DEPTH_MAX:     cfg_q.depth_max     <= cfg_data_i[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pixel payload gathered into one item.
  always_comb begin
    pixel.disparity    = disparity_i;
    pixel.disparity_ok = disparity_ok_i;
    pixel.point_x      = point_x_i;
    pixel.point_y      = point_y_i;
    pixel.point_z      = point_z_i;
    pixel.point_ok     = point_ok_i;
    pixel.end_of_frame = end_of_frame_i;
  end

  dpfs_filter #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_DECIMATION (MAX_DECIMATION),
    .MIN_DISPARITY  (MIN_DISPARITY),
    .MAX_ABS_COORD  (MAX_ABS_COORD)
  ) u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel),
    .load_ok_i  (load_ok),
    .load_o     (load)
  );

  dpfs_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .load_ok_o    (load_ok),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .grid_col_o   (grid_col_o),
    .grid_row_o   (grid_row_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .stat_id_o    (stat_id_o),
    .stat_value_o (stat_value_o),
    .last_o       (last_o)
  );

endmodule

### rtl/dpfs_checker.sv
`include "depth_point_filter_stats_unit_assert.svh"

module dpfs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [dpfs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input logic [dpfs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic signed [dpfs_pkg::DISP_W-1:0]  disparity_i,
  input logic                                disparity_ok_i,
  input logic signed [dpfs_pkg::COORD_W-1:0] point_x_i,
  input logic signed [dpfs_pkg::COORD_W-1:0] point_y_i,
  input logic signed [dpfs_pkg::COORD_W-1:0] point_z_i,
  input logic                                point_ok_i,
  input logic                                end_of_frame_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                kind_o,
  input logic [dpfs_pkg::GRID_W-1:0]         grid_col_o,
  input logic [dpfs_pkg::GRID_W-1:0]         grid_row_o,
  input logic signed [dpfs_pkg::COORD_W-1:0] out_x_o,
  input logic signed [dpfs_pkg::COORD_W-1:0] out_y_o,
  input logic signed [dpfs_pkg::COORD_W-1:0] out_z_o,
  input logic [dpfs_pkg::STAT_ID_W-1:0]      stat_id_o,
  input logic signed [dpfs_pkg::STAT_W-1:0]  stat_value_o,
  input logic                                last_o
);
  import dpfs_pkg::*;

  // A stalled result item keeps its contents.
  `DPFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(stat_id_o) && $stable(stat_value_o) && $stable(out_z_o) && $stable(last_o))

  // A point item carries no statistic and never ends the run.
  `DPFS_ASSERT_NOW(a_point_clean, clk_i, rst_ni, out_valid_o && kind_o == KIND_POINT, stat_id_o == STAT_CANDIDATES && stat_value_o == '0 && !last_o)

  // Only the sum statistic closes a frame.
  `DPFS_ASSERT_NOW(a_last_is_sum, clk_i, rst_ni, out_valid_o && last_o, kind_o == KIND_STAT && stat_id_o == STAT_SUM)

  // Statistics leave in unbroken order once started.
  `DPFS_ASSERT_NEXT(a_stat_order, clk_i, rst_ni, out_valid_o && out_ready_i && kind_o == KIND_STAT && stat_id_o != STAT_SUM, out_valid_o && kind_o == KIND_STAT && stat_id_o == $past(stat_id_o) + 4'd1)

endmodule

bind depth_point_filter_stats_unit dpfs_checker u_dpfs_checker (.*);
